@@ rtl/decimal_text_to_fixed_point_defines.svh @@
// Assertion macros shared by the decimal text to fixed point RTL.
// The macros expect signals named clk and rst_n in the scope of use.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTFP_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtfp: next-cycle check failed");

`endif

@@ rtl/dtfp_pkg.sv @@
// Package for the decimal text to fixed point block: widths, payload and
// job types, parser and back-end state types, and the power-of-ten table.
`default_nettype none

package dtfp_pkg;

    localparam int CHAR_W          = 8;
    localparam int INT_W           = 31;
    localparam int FRAC_W          = 24;
    localparam int FRAC_BITS       = 24;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int DIGITS_W        = 30;
    localparam int COUNT_W         = 4;
    localparam int STEP_W          = $clog2(FRAC_BITS);

    localparam logic [INT_W-1:0]  INT_MAX         = {INT_W{1'b1}};
    localparam logic [STEP_W-1:0] LAST_STEP       = STEP_W'(FRAC_BITS - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT      = COUNT_W'(MAX_FRAC_DIGITS);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } dtfp_in_t;

    typedef struct packed {
        logic              is_negative;
        logic [INT_W-1:0]  integer_part;
        logic [FRAC_W-1:0] fraction_part;
        logic              overflowed;
    } dtfp_out_t;

    // One parsed number waiting for its fraction conversion.
    typedef struct packed {
        logic                is_negative;
        logic [INT_W-1:0]    integer_part;
        logic                overflowed;
        logic [DIGITS_W-1:0] digits;
        logic [COUNT_W-1:0]  count;
    } dtfp_job_t;

    typedef struct packed {
        logic      push;
        dtfp_job_t job;
    } dtfp_push_t;

    typedef struct packed {
        logic      avail;
        dtfp_job_t job;
    } dtfp_head_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } dtfp_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } dtfp_bk_state_t;

    function automatic logic [DIGITS_W-1:0] pow10(input logic [COUNT_W-1:0] cnt);
        logic [DIGITS_W-1:0] p;
        unique case (cnt)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/dtfp_front.sv @@
// Front end: parses one character per transfer and queues a finished job
// when the last character of a string arrives. Depends on dtfp_pkg.
`default_nettype none

module dtfp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire dtfp_pkg::dtfp_in_t in_data,
    input  wire logic              queue_full,
    output logic                   in_ready,
    output dtfp_pkg::dtfp_push_t   push_out
);

    dtfp_pkg::dtfp_phase_t                phase_reg, phase_next;
    logic                                 neg_reg, neg_next;
    logic [dtfp_pkg::INT_W-1:0]           acc_reg, acc_next;
    logic                                 sat_reg, sat_next;
    logic [dtfp_pkg::DIGITS_W-1:0]        dig_reg, dig_next;
    logic [dtfp_pkg::COUNT_W-1:0]         cnt_reg, cnt_next;

    logic                                 is_digit;
    logic                                 is_blank;
    logic [3:0]                           digit_val;
    logic [dtfp_pkg::CHAR_W-1:0]          ch;
    logic [dtfp_pkg::INT_W+3:0]           acc_wide;
    logic [dtfp_pkg::DIGITS_W-1:0]        dig_wide;

    assign in_ready = !queue_full;
    assign ch       = in_data.char_code;
    assign is_digit = (ch >= dtfp_pkg::CH_ZERO) && (ch <= dtfp_pkg::CH_NINE);
    assign is_blank = (ch == dtfp_pkg::CH_SPACE) || (ch == dtfp_pkg::CH_TAB) ||
                      (ch == dtfp_pkg::CH_LF) || (ch == dtfp_pkg::CH_VT) ||
                      (ch == dtfp_pkg::CH_FF) || (ch == dtfp_pkg::CH_CR);
    assign digit_val = 4'(ch - dtfp_pkg::CH_ZERO);

    // Times ten as two shifts and an add.
    assign acc_wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                      {31'b0, digit_val};
    assign dig_wide = (dig_reg << 3) + (dig_reg << 1) + {26'b0, digit_val};

    always_comb
    begin
        logic take_int;
        logic take_frac;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        take_int   = 1'b0;
        take_frac  = 1'b0;
        push_out   = '0;

        if (in_valid && in_ready)
        begin
            unique case (phase_reg)
                dtfp_pkg::PH_SPACE:
                begin
                    if (is_blank)
                    begin
                        phase_next = dtfp_pkg::PH_SPACE;
                    end
                    else if (ch == dtfp_pkg::CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = dtfp_pkg::PH_INT;
                    end
                    else if (ch == dtfp_pkg::CH_PLUS)
                    begin
                        phase_next = dtfp_pkg::PH_INT;
                    end
                    else if (is_digit)
                    begin
                        take_int   = 1'b1;
                        phase_next = dtfp_pkg::PH_INT;
                    end
                    else if (ch == dtfp_pkg::CH_DOT)
                    begin
                        phase_next = dtfp_pkg::PH_FRAC;
                    end
                    else
                    begin
                        phase_next = dtfp_pkg::PH_STOP;
                    end
                end
                dtfp_pkg::PH_INT:
                begin
                    if (is_digit)
                    begin
                        take_int = 1'b1;
                    end
                    else if (ch == dtfp_pkg::CH_DOT)
                    begin
                        phase_next = dtfp_pkg::PH_FRAC;
                    end
                    else
                    begin
                        phase_next = dtfp_pkg::PH_STOP;
                    end
                end
                dtfp_pkg::PH_FRAC:
                begin
                    if (is_digit)
                    begin
                        take_frac = 1'b1;
                    end
                    else
                    begin
                        phase_next = dtfp_pkg::PH_STOP;
                    end
                end
                dtfp_pkg::PH_STOP:
                begin
                    phase_next = dtfp_pkg::PH_STOP;
                end
                default:
                begin
                    phase_next = dtfp_pkg::PH_STOP;
                end
            endcase

            if (take_int && !sat_reg)
            begin
                if (acc_wide > {4'b0, dtfp_pkg::INT_MAX})
                begin
                    acc_next = dtfp_pkg::INT_MAX;
                    sat_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_wide[dtfp_pkg::INT_W-1:0];
                end
            end

            // Digits past the maximum count are taken but leave no trace.
            if (take_frac && (cnt_reg < dtfp_pkg::MAX_COUNT))
            begin
                dig_next = dig_wide;
                cnt_next = cnt_reg + 4'd1;
            end

            if (in_data.last_char)
            begin
                push_out.push             = 1'b1;
                push_out.job.is_negative  = neg_next;
                push_out.job.integer_part = acc_next;
                push_out.job.overflowed   = sat_next;
                push_out.job.digits       = dig_next;
                push_out.job.count        = cnt_next;
                phase_next = dtfp_pkg::PH_SPACE;
                neg_next   = 1'b0;
                acc_next   = '0;
                sat_next   = 1'b0;
                dig_next   = '0;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dtfp_pkg::PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            dig_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
            dig_reg   <= dig_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dtfp_fifo.sv @@
// Two-entry job queue between the parser and the fraction converter.
// Depends on dtfp_pkg.
`default_nettype none

module dtfp_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dtfp_pkg::dtfp_push_t push_in,
    input  wire logic                 pop,
    output logic                      full,
    output dtfp_pkg::dtfp_head_t      head
);

    dtfp_pkg::dtfp_job_t mem [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                do_pop;

    assign full       = (count_reg == 2'd2);
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.avail = (count_reg != 2'd0);
    assign head.job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_in.push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, push_in.push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            mem[wr_ptr_reg] <= push_in.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dtfp_back.sv @@
// Back end: takes a queued job, converts the fraction digits to binary with
// a one-bit-per-cycle restoring divider, and holds the result for transfer.
// Depends on dtfp_pkg and decimal_text_to_fixed_point_defines.svh.
`default_nettype none
`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dtfp_pkg::dtfp_head_t head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output dtfp_pkg::dtfp_out_t       out_data
);

    dtfp_pkg::dtfp_bk_state_t          state_reg, state_next;
    logic [dtfp_pkg::STEP_W-1:0]       step_reg, step_next;
    logic [dtfp_pkg::DIGITS_W-1:0]     rem_reg, rem_next;
    logic [dtfp_pkg::DIGITS_W-1:0]     div_reg, div_next;
    logic [dtfp_pkg::FRAC_BITS-1:0]    q_reg, q_next;
    logic                              neg_reg, neg_next;
    logic [dtfp_pkg::INT_W-1:0]        int_reg, int_next;
    logic                              ovf_reg, ovf_next;

    logic [dtfp_pkg::DIGITS_W:0]       rem_shift;
    logic                              q_bit;

    // The remainder stays below the divisor, so twice it fits one extra bit.
    assign rem_shift = {rem_reg, 1'b0};
    assign q_bit     = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        ovf_next   = ovf_reg;
        pop        = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            dtfp_pkg::BK_IDLE:
            begin
                if (head.avail)
                begin
                    pop        = 1'b1;
                    rem_next   = head.job.digits;
                    div_next   = dtfp_pkg::pow10(head.job.count);
                    q_next     = '0;
                    neg_next   = head.job.is_negative;
                    int_next   = head.job.integer_part;
                    ovf_next   = head.job.overflowed;
                    step_next  = '0;
                    state_next = dtfp_pkg::BK_DIV;
                end
            end
            dtfp_pkg::BK_DIV:
            begin
                if (q_bit)
                begin
                    rem_next = dtfp_pkg::DIGITS_W'(rem_shift - {1'b0, div_reg});
                end
                else
                begin
                    rem_next = rem_shift[dtfp_pkg::DIGITS_W-1:0];
                end
                q_next    = {q_reg[dtfp_pkg::FRAC_BITS-2:0], q_bit};
                step_next = step_reg + 1'b1;
                if (step_reg == dtfp_pkg::LAST_STEP)
                begin
                    state_next = dtfp_pkg::BK_DONE;
                end
            end
            dtfp_pkg::BK_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = dtfp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dtfp_pkg::BK_IDLE;
            end
        endcase
    end

    assign out_data.is_negative   = neg_reg;
    assign out_data.integer_part  = int_reg;
    assign out_data.fraction_part = q_reg[dtfp_pkg::FRAC_W-1:0];
    assign out_data.overflowed    = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtfp_pkg::BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        int_reg <= int_next;
        ovf_reg <= ovf_next;
    end

    `DTFP_ASSERT(a_pop_needs_job, pop, head.avail && (state_reg == dtfp_pkg::BK_IDLE))
    `DTFP_ASSERT(a_rem_below_div, state_reg == dtfp_pkg::BK_DIV, rem_reg < div_reg)
    `DTFP_ASSERT(a_div_nonzero, state_reg == dtfp_pkg::BK_DIV, div_reg != '0)
    `DTFP_ASSERT_NEXT(a_div_ends, (state_reg == dtfp_pkg::BK_DIV) && (step_reg == dtfp_pkg::LAST_STEP), state_reg == dtfp_pkg::BK_DONE)

endmodule

`default_nettype wire

@@ rtl/decimal_text_to_fixed_point.sv @@
// Decimal text to fixed point converter. The parser takes one character per
// cycle; each string marked last becomes a job in a two-entry queue. The
// converter turns the fraction digits into a Q0.24 value with a restoring
// divider that makes one quotient bit per cycle. When the converter is idle, it
// takes the job in the cycle after the last character transfers, and the
// result is held until it is transferred. Per number the converter takes the
// job, divides out FRAC_BITS = 24 quotient bits and presents the result; it
// takes no new job until that result has transferred. Input stalls only while
// both queue entries are occupied. That happens when short strings arrive
// back to back, or when the result side holds off. Depends on dtfp_pkg and
// the dtfp_* modules.
`default_nettype none

module decimal_text_to_fixed_point (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dtfp_pkg::dtfp_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dtfp_pkg::dtfp_out_t     out_data
);

    dtfp_pkg::dtfp_push_t push_bus;
    dtfp_pkg::dtfp_head_t head_bus;
    logic                 queue_full;
    logic                 pop;

    dtfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .queue_full (queue_full),
        .in_ready   (in_ready),
        .push_out   (push_bus)
    );

    dtfp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push_bus),
        .pop     (pop),
        .full    (queue_full),
        .head    (head_bus)
    );

    dtfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_bus),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
